FILE: design/mbrtu_pkg.sv
package mbrtu_pkg;

   localparam int unsigned RX_W     = 8;
   localparam int unsigned CRC_W    = 16;
   localparam int unsigned CSR_W    = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 64;

   // reply bytes kept for the final check; the seventh one is used as it arrives
   localparam int unsigned REPLY_KEEP = 6;
   localparam logic [2:0]  REPLY_LAST = 3'd6;
   localparam logic [2:0]  CRC_BYTES  = 3'd5;
   localparam logic [2:0]  TX_LAST    = 3'd7;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]       FC_READ_HOLDING = 8'h03;
   localparam logic [7:0]       BYTE_COUNT_ONE_REG = 8'h02;
   localparam logic [7:0]       QTY_HI = 8'h00;
   localparam logic [7:0]       QTY_LO = 8'h01;

   typedef enum logic [1:0] {
      FUNC_START   = 2'd0,
      FUNC_BYTE    = 2'd1,
      FUNC_TIMEOUT = 2'd2,
      FUNC_UNUSED  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_SLAVE      = 3'd0,
      CSR_REG_ADDR   = 3'd1,
      CSR_SCALE      = 3'd2,
      CSR_ALARM_HIGH = 3'd3,
      CSR_ALARM_LOW  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_TIMEOUT = 2'd1,
      ST_CRC     = 2'd2,
      ST_FRAME   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ALARM_NONE = 2'd0,
      ALARM_HIGH = 2'd1,
      ALARM_LOW  = 2'd2
   } alarm_type;

   typedef enum logic {
      KIND_TX     = 1'b0,
      KIND_RESULT = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'b01,
      PH_WAIT = 2'b10
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_byte;
      logic        last;
      status_type  status;
      logic [15:0] raw_value;
      logic [31:0] scaled_value;
      alarm_type   alarm;
   } rsp_type;

   // crc-16/modbus, one byte, bit steps unrolled
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: design/modbus_rtu_register_poll_master.sv
// Modbus RTU master reading one holding register (function code 3).
// req_ channel: one request per item; req_tuser is the function (start, received
// byte, timeout) and req_tdata the received line byte.
// rsp_ channel: a start gives eight transmit bytes (slave, 0x03, address, quantity
// one, crc low byte first), the eighth flagged by rsp_tlast; the seventh reply
// byte or a timeout while waiting gives one read result with status, raw value,
// value times scale and alarm. Other requests give nothing.
// csr_ port: register writes, taken on any edge with csr_we high.
// A request waits in the input register and its result is then registered in the
// output register that drives rsp_tvalid. Requests are taken one per cycle unless
// a result waits for the output register; a start holds the input register until
// its eight transmit bytes have gone out, since the output register moves one byte
// a cycle while rsp_tready is high. The crc of the outgoing frame is built one byte
// step per transmitted byte over the first six bytes.
// When rsp_tready is low the output register holds its result; a request that has
// a result then waits in the input register and req_tready drops, while requests
// with no result still pass through.
// Reset empties both registers, returns the block to idle and loads the
// register defaults (slave 1, scale 100, alarms off).
module modbus_rtu_register_poll_master (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] tx_byte, [9:8] status, [25:10] raw_value, [57:26] scaled_value,
   // [59:58] alarm, [63:60] zero
   output logic [63:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration
   logic [7:0]  slave_ff;
   logic [15:0] reg_addr_ff;
   logic [15:0] scale_ff;
   logic [15:0] alarm_high_ff;
   logic [15:0] alarm_low_ff;

   // input register
   logic                 in_valid_ff, in_valid_in;
   mbrtu_pkg::func_type  in_func_ff;
   logic [7:0]           in_rx_ff;

   // read state
   mbrtu_pkg::phase_type phase_ff, phase_in;
   logic [2:0]           count_ff, count_in;
   logic [15:0]          run_crc_ff, run_crc_in;
   logic [7:0]           reply_ff [mbrtu_pkg::REPLY_KEEP];
   logic [2:0]           tx_cnt_ff, tx_cnt_in;
   logic [15:0]          tx_crc_ff, tx_crc_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   mbrtu_pkg::rsp_type   rsp_ff, rsp_in;

   logic        out_free, has_res, consume, fire, waiting, reply_done;
   logic [15:0] tx_crc_base;
   logic [7:0]  tx_byte;
   logic        crc_ok, frame_ok;
   logic [15:0] raw;
   logic [31:0] product;
   mbrtu_pkg::alarm_type alarm;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign waiting    = (phase_ff == mbrtu_pkg::PH_WAIT);
   assign reply_done = (count_ff == mbrtu_pkg::REPLY_LAST);

   always_comb begin
      has_res = 1'b0;
      case (in_func_ff)
         mbrtu_pkg::FUNC_START:   has_res = 1'b1;
         mbrtu_pkg::FUNC_BYTE:    has_res = waiting && reply_done;
         mbrtu_pkg::FUNC_TIMEOUT: has_res = waiting;
         default:                 has_res = 1'b0;
      endcase
   end

   // a start stays in the input register until its last byte goes out
   assign fire    = in_valid_ff && has_res && out_free;
   assign consume = in_valid_ff && (!has_res || out_free) &&
                    (in_func_ff != mbrtu_pkg::FUNC_START || tx_cnt_ff == mbrtu_pkg::TX_LAST);
   assign req_tready = !in_valid_ff || consume;

   // request frame bytes
   assign tx_crc_base = (tx_cnt_ff == 3'd0) ? mbrtu_pkg::CRC_INIT : tx_crc_ff;

   always_comb begin
      tx_byte = 8'h00;
      case (tx_cnt_ff)
         3'd0:    tx_byte = slave_ff;
         3'd1:    tx_byte = mbrtu_pkg::FC_READ_HOLDING;
         3'd2:    tx_byte = reg_addr_ff[15:8];
         3'd3:    tx_byte = reg_addr_ff[7:0];
         3'd4:    tx_byte = mbrtu_pkg::QTY_HI;
         3'd5:    tx_byte = mbrtu_pkg::QTY_LO;
         3'd6:    tx_byte = tx_crc_ff[7:0];
         default: tx_byte = tx_crc_ff[15:8];
      endcase
   end

   // reply check, the crc high byte is the one arriving now
   assign crc_ok   = (run_crc_ff == {in_rx_ff, reply_ff[5]});
   assign frame_ok = (reply_ff[0] == slave_ff) &&
                     (reply_ff[1] == mbrtu_pkg::FC_READ_HOLDING) &&
                     (reply_ff[2] == mbrtu_pkg::BYTE_COUNT_ONE_REG);
   assign raw      = {reply_ff[3], reply_ff[4]};
   assign product  = 32'(raw) * 32'(scale_ff);

   always_comb begin
      if (alarm_high_ff != 16'd0 && raw > alarm_high_ff) begin
         alarm = mbrtu_pkg::ALARM_HIGH;
      end else if (alarm_low_ff != 16'd0 && raw < alarm_low_ff) begin
         alarm = mbrtu_pkg::ALARM_LOW;
      end else begin
         alarm = mbrtu_pkg::ALARM_NONE;
      end
   end

   always_comb begin
      rsp_in = '0;
      if (in_func_ff == mbrtu_pkg::FUNC_START) begin
         rsp_in.kind    = mbrtu_pkg::KIND_TX;
         rsp_in.tx_byte = tx_byte;
         rsp_in.last    = (tx_cnt_ff == mbrtu_pkg::TX_LAST);
      end else if (in_func_ff == mbrtu_pkg::FUNC_TIMEOUT) begin
         rsp_in.kind   = mbrtu_pkg::KIND_RESULT;
         rsp_in.status = mbrtu_pkg::ST_TIMEOUT;
      end else begin
         rsp_in.kind = mbrtu_pkg::KIND_RESULT;
         if (!crc_ok) begin
            rsp_in.status = mbrtu_pkg::ST_CRC;
         end else if (!frame_ok) begin
            rsp_in.status = mbrtu_pkg::ST_FRAME;
         end else begin
            rsp_in.status       = mbrtu_pkg::ST_OK;
            rsp_in.raw_value    = raw;
            rsp_in.scaled_value = product;
            rsp_in.alarm        = alarm;
         end
      end
   end

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   // read state update
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      run_crc_in = run_crc_ff;
      tx_cnt_in  = tx_cnt_ff;
      tx_crc_in  = tx_crc_ff;
      if (in_valid_ff && in_func_ff == mbrtu_pkg::FUNC_START && out_free) begin
         tx_cnt_in = tx_cnt_ff + 3'd1;
         // the crc bytes themselves are kept out of the crc
         if (tx_cnt_ff < 3'd6) begin
            tx_crc_in = mbrtu_pkg::crc_byte(tx_crc_base, tx_byte);
         end
      end
      if (consume) begin
         unique case (phase_ff)
            mbrtu_pkg::PH_IDLE: begin
               if (in_func_ff == mbrtu_pkg::FUNC_START) begin
                  phase_in   = mbrtu_pkg::PH_WAIT;
                  count_in   = 3'd0;
                  run_crc_in = mbrtu_pkg::CRC_INIT;
               end
            end
            mbrtu_pkg::PH_WAIT: begin
               case (in_func_ff)
                  mbrtu_pkg::FUNC_START: begin
                     count_in   = 3'd0;
                     run_crc_in = mbrtu_pkg::CRC_INIT;
                  end
                  mbrtu_pkg::FUNC_TIMEOUT: begin
                     phase_in = mbrtu_pkg::PH_IDLE;
                     count_in = 3'd0;
                  end
                  mbrtu_pkg::FUNC_BYTE: begin
                     if (count_ff < mbrtu_pkg::CRC_BYTES) begin
                        run_crc_in = mbrtu_pkg::crc_byte(run_crc_ff, in_rx_ff);
                     end
                     if (reply_done) begin
                        phase_in = mbrtu_pkg::PH_IDLE;
                        count_in = 3'd0;
                     end else begin
                        count_in = count_ff + 3'd1;
                     end
                  end
                  default: ;
               endcase
            end
            default: phase_in = mbrtu_pkg::PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff      <= 8'd1;
         reg_addr_ff   <= 16'd0;
         scale_ff      <= 16'd100;
         alarm_high_ff <= 16'd0;
         alarm_low_ff  <= 16'd0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= mbrtu_pkg::PH_IDLE;
         count_ff      <= 3'd0;
         run_crc_ff    <= mbrtu_pkg::CRC_INIT;
         tx_cnt_ff     <= 3'd0;
         tx_crc_ff     <= mbrtu_pkg::CRC_INIT;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mbrtu_pkg::CSR_SLAVE:      slave_ff      <= csr_wdata[7:0];
               mbrtu_pkg::CSR_REG_ADDR:   reg_addr_ff   <= csr_wdata;
               mbrtu_pkg::CSR_SCALE:      scale_ff      <= csr_wdata;
               mbrtu_pkg::CSR_ALARM_HIGH: alarm_high_ff <= csr_wdata;
               mbrtu_pkg::CSR_ALARM_LOW:  alarm_low_ff  <= csr_wdata;
               default: ;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         run_crc_ff   <= run_crc_in;
         tx_cnt_ff    <= tx_cnt_in;
         tx_crc_ff    <= tx_crc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_func_ff <= mbrtu_pkg::func_type'(req_tuser);
         in_rx_ff   <= req_tdata;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
      if (consume && waiting && in_func_ff == mbrtu_pkg::FUNC_BYTE) begin
         for (int i = 0; i < int'(mbrtu_pkg::REPLY_KEEP); i++) begin
            if (count_ff == 3'(i)) begin
               reply_ff[i] <= in_rx_ff;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {4'h0, rsp_ff.alarm, rsp_ff.scaled_value, rsp_ff.raw_value,
                        rsp_ff.status, rsp_ff.tx_byte};

endmodule

FILE: design/mbrtu_checker.sv
module mbrtu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // a read result never closes a request frame
   a_result_no_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast)
      else $error("read result flagged as frame end");

   // transmit bytes carry nothing beyond the byte itself
   a_tx_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[63:8] == 56'd0)
      else $error("transmit byte with result fields set");

   // failed reads report no value and no alarm
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata[9:8] != 2'd0
      |-> rsp_tdata[59:10] == 50'd0)
      else $error("failed read carries a value");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready
      |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

endmodule

bind modbus_rtu_register_poll_master mbrtu_checker u_mbrtu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: sim/modbus_rtu_register_poll_master_tb.sv
`timescale 1ns / 100ps

module modbus_rtu_register_poll_master_tb;

   import mbrtu_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned ITEM_TARGET   = 380;
   localparam int unsigned RANDOM_PASSES = 6;

   typedef struct {
      kind_type    kind;
      logic [7:0]  tx_byte;
      logic        last;
      status_type  status;
      logic [15:0] raw_value;
      logic [31:0] scaled_value;
      alarm_type   alarm;
   } poll_out_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] rx_byte
   logic [1:0]  req_tuser = '0;    // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   // [7:0] tx_byte, [9:8] status, [25:10] raw_value, [57:26] scaled_value,
   // [59:58] alarm, [63:60] zero
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;         // [0] kind
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // outputs still owed by the block, oldest first
   poll_out_t   awaited_out[$];

   // register copy and poll state mirrored by the predictor
   logic [7:0]  cfg_slave;
   logic [15:0] cfg_reg_addr;
   logic [15:0] cfg_scale;
   logic [15:0] cfg_alarm_high;
   logic [15:0] cfg_alarm_low;
   phase_type   poll_phase;
   int          reply_count;
   logic [7:0]  reply_bytes [7];
   logic [15:0] reply_crc;

   int          errors = 0;
   int          sent_items = 0;
   int          cycle_count = 0;
   int          stall_left = 0;
   bit          gap_on = 1'b1;
   bit          stall_on = 1'b1;

   modbus_rtu_register_poll_master i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver back-pressure in bursts of random length
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] data);
      logic [15:0] r;
      logic        lsb;
      r = acc ^ {8'h00, data};
      repeat (8) begin
         lsb = r[0];
         r = r >> 1;
         if (lsb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void push_out(kind_type k, logic [7:0] tx, logic lst, status_type st,
                                    logic [15:0] raw, logic [31:0] scaled, alarm_type al);
      poll_out_t o;
      o.kind = k;
      o.tx_byte = tx;
      o.last = lst;
      o.status = st;
      o.raw_value = raw;
      o.scaled_value = scaled;
      o.alarm = al;
      awaited_out.push_back(o);
   endfunction

   function automatic void predict_poll(func_type f, logic [7:0] b);
      logic [7:0]  frame [8];
      logic [15:0] c;
      logic [15:0] raw;
      status_type  st;
      alarm_type   al;
      case (f)
         FUNC_START: begin
            frame[0] = cfg_slave;
            frame[1] = FC_READ_HOLDING;
            frame[2] = cfg_reg_addr[15:8];
            frame[3] = cfg_reg_addr[7:0];
            frame[4] = QTY_HI;
            frame[5] = QTY_LO;
            c = CRC_INIT;
            for (int i = 0; i < 6; i++) c = crc16_step(c, frame[i]);
            frame[6] = c[7:0];
            frame[7] = c[15:8];
            for (int i = 0; i < 8; i++)
               push_out(KIND_TX, frame[i], i == 7, ST_OK, '0, '0, ALARM_NONE);
            // a pending read is dropped silently
            poll_phase = PH_WAIT;
            reply_count = 0;
            reply_crc = CRC_INIT;
         end
         FUNC_TIMEOUT: begin
            if (poll_phase == PH_WAIT) begin
               push_out(KIND_RESULT, '0, 1'b0, ST_TIMEOUT, '0, '0, ALARM_NONE);
               poll_phase = PH_IDLE;
               reply_count = 0;
            end
         end
         FUNC_BYTE: begin
            if (poll_phase == PH_WAIT) begin
               reply_bytes[reply_count] = b;
               if (reply_count < 5) reply_crc = crc16_step(reply_crc, b);
               reply_count++;
               if (reply_count == 7) begin
                  poll_phase = PH_IDLE;
                  reply_count = 0;
                  // crc is judged before the header fields
                  if (reply_crc != {reply_bytes[6], reply_bytes[5]})
                     st = ST_CRC;
                  else if (reply_bytes[0] != cfg_slave || reply_bytes[1] != FC_READ_HOLDING
                           || reply_bytes[2] != BYTE_COUNT_ONE_REG)
                     st = ST_FRAME;
                  else
                     st = ST_OK;
                  if (st != ST_OK) begin
                     push_out(KIND_RESULT, '0, 1'b0, st, '0, '0, ALARM_NONE);
                  end else begin
                     raw = {reply_bytes[3], reply_bytes[4]};
                     al = ALARM_NONE;
                     if (cfg_alarm_high != 0 && raw > cfg_alarm_high) al = ALARM_HIGH;
                     else if (cfg_alarm_low != 0 && raw < cfg_alarm_low) al = ALARM_LOW;
                     push_out(KIND_RESULT, '0, 1'b0, ST_OK, raw,
                              32'(raw) * 32'(cfg_scale), al);
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      poll_out_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_out.size() == 0) begin
            $error("unexpected response: kind %0h, tdata %h, last %0h",
                   rsp_tuser, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = awaited_out.pop_front();
            check_field("kind", want.kind, rsp_tuser);
            check_field("tx_byte", want.tx_byte, rsp_tdata[7:0]);
            check_field("last", want.last, rsp_tlast);
            check_field("status", want.status, rsp_tdata[9:8]);
            check_field("raw_value", want.raw_value, rsp_tdata[25:10]);
            check_field("scaled_value", want.scaled_value, rsp_tdata[57:26]);
            check_field("alarm", want.alarm, rsp_tdata[59:58]);
         end
      end
   end

   task automatic send_request(func_type f, logic [7:0] b);
      if (gap_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      predict_poll(f, b);
      sent_items++;
   endtask

   // sends the first n_bytes of a reply frame; crc_flip spoils the crc
   task automatic send_reply(logic [7:0] sid, logic [7:0] fc, logic [7:0] count,
                             logic [15:0] raw, logic [15:0] crc_flip, int n_bytes);
      logic [7:0]  r [7];
      logic [15:0] c;
      r[0] = sid;
      r[1] = fc;
      r[2] = count;
      r[3] = raw[15:8];
      r[4] = raw[7:0];
      c = CRC_INIT;
      for (int i = 0; i < 5; i++) c = crc16_step(c, r[i]);
      c = c ^ crc_flip;
      r[5] = c[7:0];
      r[6] = c[15:8];
      for (int i = 0; i < n_bytes; i++) send_request(FUNC_BYTE, r[i]);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (awaited_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [15:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         CSR_SLAVE:      cfg_slave = v[7:0];
         CSR_REG_ADDR:   cfg_reg_addr = v;
         CSR_SCALE:      cfg_scale = v;
         CSR_ALARM_HIGH: cfg_alarm_high = v;
         CSR_ALARM_LOW:  cfg_alarm_low = v;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [15:0] slave, logic [15:0] addr, logic [15:0] scale,
                             logic [15:0] high, logic [15:0] low);
      write_register(CSR_SLAVE, slave);
      write_register(CSR_REG_ADDR, addr);
      write_register(CSR_SCALE, scale);
      write_register(CSR_ALARM_HIGH, high);
      write_register(CSR_ALARM_LOW, low);
      csr_we <= 1'b0;
   endtask

   task automatic test_idle_requests();
      send_request(FUNC_BYTE, 8'hFF);
      send_request(FUNC_TIMEOUT, 8'h00);
      send_request(FUNC_UNUSED, 8'hA5);
      send_request(FUNC_BYTE, 8'h00);
   endtask

   task automatic test_good_read();
      send_request(FUNC_START, 8'h5A);
      send_reply(cfg_slave, FC_READ_HOLDING, BYTE_COUNT_ONE_REG, 16'hFFFF, 16'h0000, 7);
   endtask

   task automatic test_timeout_mid_reply();
      send_request(FUNC_START, 8'hC3);
      send_reply(cfg_slave, FC_READ_HOLDING, BYTE_COUNT_ONE_REG, 16'h1234, 16'h0000, 3);
      send_request(FUNC_TIMEOUT, 8'h3C);
   endtask

   task automatic test_restart_while_waiting();
      send_request(FUNC_START, 8'h00);
      send_request(FUNC_BYTE, cfg_slave);
      send_request(FUNC_START, 8'hFF);
      send_request(FUNC_TIMEOUT, 8'h81);
   endtask

   task automatic test_random_polls();
      int          pick;
      int          target;
      logic [15:0] raw;
      logic [7:0]  sid;
      logic [7:0]  fc;
      logic [7:0]  count;
      logic [15:0] flip;
      for (int p = 0; p < RANDOM_PASSES; p++) begin
         wait_idle();
         if (p == 1)
            set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
         else if (p == 2)
            set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         else
            set_config(pick16(), pick16(), pick16(), pick16(), pick16());
         // no idling at all in the closing pass, receiver never stalls in pass 3
         gap_on = (p < RANDOM_PASSES - 1);
         stall_on = (p < RANDOM_PASSES - 1) && (p != 3);
         target = ITEM_TARGET * (p + 1) / RANDOM_PASSES;
         while (sent_items < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
               send_request(func_type'($urandom_range(0, 3)), rand_byte());
            end else if (pick < 5) begin
               // cut short by a timeout or a fresh start
               send_request(FUNC_START, rand_byte());
               send_reply(cfg_slave, FC_READ_HOLDING, BYTE_COUNT_ONE_REG, 16'($urandom),
                          16'h0000, $urandom_range(0, 6));
               if ($urandom_range(0, 2) == 0) send_request(FUNC_START, rand_byte());
               else send_request(FUNC_TIMEOUT, rand_byte());
            end else begin
               sid = cfg_slave;
               fc = FC_READ_HOLDING;
               count = BYTE_COUNT_ONE_REG;
               flip = 16'h0000;
               case ($urandom_range(0, 7))
                  0: raw = 16'h0000;
                  1: raw = 16'hFFFF;
                  2: raw = cfg_alarm_high;
                  3: raw = cfg_alarm_high + 16'd1;
                  4: raw = cfg_alarm_low;
                  5: raw = cfg_alarm_low - 16'd1;
                  default: raw = 16'($urandom);
               endcase
               if (pick < 9) begin
                  case ($urandom_range(0, 3))
                     0: flip = 16'($urandom_range(1, 65535));
                     1: sid = sid ^ 8'($urandom_range(1, 255));
                     2: fc = fc ^ 8'($urandom_range(1, 255));
                     default: count = count ^ 8'($urandom_range(1, 255));
                  endcase
               end
               send_request(FUNC_START, rand_byte());
               send_reply(sid, fc, count, raw, flip, 7);
               // late timeout after a complete reply is ignored
               if ($urandom_range(0, 5) == 0) send_request(FUNC_TIMEOUT, rand_byte());
            end
         end
      end
      wait_idle();
   endtask

   initial begin
      cfg_slave = 8'd1;
      cfg_reg_addr = 16'd0;
      cfg_scale = 16'd100;
      cfg_alarm_high = 16'd0;
      cfg_alarm_low = 16'd0;
      poll_phase = PH_IDLE;
      reply_count = 0;
      reply_crc = CRC_INIT;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_idle_requests();
      test_good_read();
      test_timeout_mid_reply();
      test_restart_while_waiting();
      test_random_polls();

      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
